// ----- rtl/b64e_pkg.sv -----
// b64e_pkg: shared types, constants and the sextet-to-ascii mapping
// for the base64 stream encoder; depends on nothing
`default_nettype none
package b64e_pkg;

  // depth of the group queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;

  // ascii codes
  localparam logic [6:0] PadChar   = 7'h3d;
  localparam logic [6:0] UpperA    = 7'h41;
  localparam logic [6:0] LowerA    = 7'h61;
  localparam logic [6:0] DigitZero = 7'h30;
  localparam logic [6:0] PlusChar  = 7'h2b;
  localparam logic [6:0] SlashChar = 7'h2f;

  // one input byte worth of characters, one to four of them
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
    logic            last;
  } group_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // map one sextet to its base64 character
  function automatic logic [6:0] enc_sextet(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      enc_sextet = UpperA + v7;
    end else if (v < 6'd52) begin
      enc_sextet = LowerA + v7 - 7'd26;
    end else if (v < 6'd62) begin
      enc_sextet = DigitZero + v7 - 7'd52;
    end else if (v == 6'd62) begin
      enc_sextet = PlusChar;
    end else begin
      enc_sextet = SlashChar;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/b64e_front.sv -----
// b64e_front: takes input beats, tracks byte phase and leftover bits,
// builds one character group per byte; uses b64e_pkg
`default_nettype none
module b64e_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  input  wire b64e_pkg::q_status_t q_status,
  output logic                    push,
  output b64e_pkg::group_t        push_group
);

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // classify the byte by phase and build its characters
  always_comb begin
    push_group.chars    = {4{b64e_pkg::PadChar}};
    push_group.last_idx = 2'd0;
    push_group.last     = in_last_byte;
    phase_nxt           = PH0;
    carry_nxt           = 4'd0;
    case (phase_r)
      PH1: begin
        push_group.chars[0] = b64e_pkg::enc_sextet({carry_r[1:0], in_data_byte[7:4]});
        if (in_last_byte) begin
          push_group.chars[1] = b64e_pkg::enc_sextet({in_data_byte[3:0], 2'b00});
          push_group.last_idx = 2'd2;
        end else begin
          carry_nxt = in_data_byte[3:0];
          phase_nxt = PH2;
        end
      end
      PH2: begin
        push_group.chars[0] = b64e_pkg::enc_sextet({carry_r[3:0], in_data_byte[7:6]});
        push_group.chars[1] = b64e_pkg::enc_sextet(in_data_byte[5:0]);
        push_group.last_idx = 2'd1;
      end
      default: begin
        push_group.chars[0] = b64e_pkg::enc_sextet(in_data_byte[7:2]);
        if (in_last_byte) begin
          push_group.chars[1] = b64e_pkg::enc_sextet({in_data_byte[1:0], 4'b0000});
          push_group.last_idx = 2'd3;
        end else begin
          carry_nxt = {2'b00, in_data_byte[1:0]};
          phase_nxt = PH1;
        end
      end
    endcase
  end

  // phase and leftover bits advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH0;
      carry_r <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // the unused phase code is never entered
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("front entered unused phase");

endmodule
`default_nettype wire

// ----- rtl/b64e_queue.sv -----
// b64e_queue: short fifo of character groups between front and back;
// uses b64e_pkg
`default_nettype none
module b64e_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire b64e_pkg::group_t    push_group,
  input  wire logic                pop,
  output b64e_pkg::group_t         pop_group,
  output b64e_pkg::q_status_t      q_status
);

  localparam logic [b64e_pkg::QAw:0] DepthC = (b64e_pkg::QAw + 1)'(b64e_pkg::QDepth);

  b64e_pkg::group_t             mem_r [b64e_pkg::QDepth];
  logic [b64e_pkg::QAw-1:0]     wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::QAw:0]       count_r;

  assign q_status.full  = (count_r == DepthC);
  assign q_status.empty = (count_r == '0);
  assign pop_group      = mem_r[rd_ptr_r];

  // pointer wrap at the queue depth
  function automatic logic [b64e_pkg::QAw-1:0] ptr_inc(input logic [b64e_pkg::QAw-1:0] p);
    if (p == b64e_pkg::QAw'(b64e_pkg::QDepth - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_group;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthC)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/b64e_back.sv -----
// b64e_back: holds one character group and sends its characters one beat
// per cycle on the result channel while out_ready is high; uses b64e_pkg
`default_nettype none
module b64e_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire b64e_pkg::q_status_t q_status,
  input  wire b64e_pkg::group_t    pop_group,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [6:0]               out_char,
  output logic                     out_last_char
);

  b64e_pkg::group_t grp_r;
  logic [1:0]       idx_r;
  logic             busy_r;
  logic             at_end;
  logic             out_fire;

  assign out_valid     = busy_r;
  assign out_fire      = busy_r && out_ready;
  assign at_end        = (idx_r == grp_r.last_idx);
  assign out_char      = grp_r.chars[idx_r];
  assign out_last_char = grp_r.last && at_end;

  // load the next group once the current one is empty or finishing
  assign pop = (!busy_r || (out_fire && at_end)) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      grp_r <= pop_group;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (out_fire) begin
      if (at_end) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= grp_r.last_idx)
    else $error("character index beyond group");

endmodule
`default_nettype wire

// ----- rtl/base64_stream_encoder.sv -----
// base64_stream_encoder: top level joining front, group queue and back;
// uses b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// Usage: one raw byte per input beat (in_data_byte, in_last_byte marks the
// final byte of a message). Standard padded base64 characters leave on the
// result channel, one per beat (out_char, out_last_char on the final one).
// Both channels use valid/ready; a beat moves when both are high.
// The first character of a byte shows on out_valid once the byte has been
// written to the group queue and then loaded into the back end group
// register; characters then leave one per cycle while out_ready is high.
// Throughput: a byte is accepted every cycle while the group queue has
// room; the back end emits one to four characters per byte (1.33 average),
// so the output port at one character per cycle sets the sustained rate.
// The queue holds two groups, so the input keeps flowing while a finished
// character waits on a stalled receiver; once it fills, in_ready drops until
// the back end takes a group.
// Reset (rst_n, synchronous, active low) clears the byte phase, the
// leftover bits, the queue and the output; no clearing pass is needed.
`default_nettype none
module base64_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char,
  output logic            out_last_char
);

  b64e_pkg::q_status_t q_status;
  b64e_pkg::group_t    push_group;
  b64e_pkg::group_t    pop_group;
  logic                push;
  logic                pop;

  // front: accept and classify
  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_status     (q_status),
    .push         (push),
    .push_group   (push_group)
  );

  // group queue
  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .pop_group  (pop_group),
    .q_status   (q_status)
  );

  // back: serialize characters
  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .pop_group     (pop_group),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule
`default_nettype wire
